>>> sv/smm_pkg.sv
`default_nettype none
package smm_pkg;

    localparam int REQ_W      = 2;
    localparam int RES_W      = 5;
    localparam int VAL_W      = 24;
    localparam int ADDR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ETA_W      = 16;
    localparam int LIMIT_W    = 32;
    localparam int SUM_W      = 32;
    localparam int DMAG_W     = 24;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 56;

    localparam logic [REQ_W-1:0] REQ_RESIDUE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

    localparam logic KIND_PRED = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ETA    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN  = 2'd3;

    typedef struct packed {
        logic res_in;
        logic load;
        logic rd_issue;
        logic add;
        logic fin;
        logic sq;
        logic out_pred;
        logic out_read;
        logic sweep_start;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic upd;
        logic sweep_busy;
    } sts_t;

endpackage
`default_nettype wire

>>> sv/smm_sgd_trainer.sv
`default_nettype none
// Channel   Dir  Handshake                Content
// s_        in   s_tvalid/s_tready        requests: residue, weight load, weight read
// m_        out  m_tvalid/m_tready        prediction result or weight read result
// cfg_      in   cfg_valid/cfg_ready      register writes: eta, lambda, error_limit, train_enable
//
// A weight load is a single memory write; a residue is one registered memory read, then one add.
// A weight read is a registered memory read, then any wait for the output register.
// After the last residue the error is formed (FIN), squared (SQ) and the update decided (DEC);
// an update then sweeps all SEQ_LEN*ALPHABET weights of the weight memory (180 at the defaults).
// Reset clears control state only; weights are undefined until loaded.
// The output register lets the next request in while a result waits on m_tready.
module smm_sgd_trainer #(
    parameter int SEQ_LEN     = 9,
    parameter int ALPHABET    = 20,
    parameter int WEIGHT_BITS = 24
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // residue[4:0], target[28:5], weight_addr[36:29], weight_value[60:37]
    input  wire logic [smm_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type[1:0]
    input  wire logic [smm_pkg::REQ_W-1:0]          s_tuser,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // prediction[23:0], updated[24], length_error[25], read_value[49:26]
    output logic [smm_pkg::M_TDATA_W-1:0]           m_tdata,
    // kind[0]
    output logic                                    m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [smm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [smm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import smm_pkg::*;

    cmd_t                    cmd;
    sts_t                    sts;
    logic signed [VAL_W-1:0] in_target, in_wval, m_pred, m_rval;
    logic                    m_upd, m_lerr;

    assign cfg_ready = 1'b1;
    assign in_target = s_tdata[28:5];
    assign in_wval   = s_tdata[60:37];
    assign m_tdata   = {6'b0, m_rval, m_lerr, m_upd, m_pred};

    smm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req      (s_tuser),
        .last     (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    smm_dp #(
        .SEQ_LEN     (SEQ_LEN),
        .ALPHABET    (ALPHABET),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_residue (s_tdata[4:0]),
        .in_target  (in_target),
        .in_addr    (s_tdata[36:29]),
        .in_wval    (in_wval),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_kind     (m_tuser),
        .m_pred     (m_pred),
        .m_upd      (m_upd),
        .m_lerr     (m_lerr),
        .m_rval     (m_rval)
    );

endmodule
`default_nettype wire

>>> sv/smm_ram.sv
`default_nettype none
module smm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 180
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/smm_ctrl.sv
`default_nettype none
module smm_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [smm_pkg::REQ_W-1:0] req,
    input  wire logic                     last,
    input  wire smm_pkg::sts_t            sts,
    output smm_pkg::cmd_t                 cmd
);
    import smm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RESW  = 3'd1;
    localparam logic [2:0] ST_FIN   = 3'd2;
    localparam logic [2:0] ST_SQ    = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;
    localparam logic [2:0] ST_RDW   = 3'd5;
    localparam logic [2:0] ST_SWEEP = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic       acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid & s_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    unique case (req)
                        REQ_LOAD: cmd.load = 1'b1;
                        REQ_READ: begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_RDW;
                        end
                        REQ_RESIDUE: begin
                            cmd.res_in = 1'b1;
                            last_next  = last;
                            state_next = ST_RESW;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RESW: begin
                cmd.add    = 1'b1;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                // hold until the output register frees up
                if (sts.out_free) begin
                    cmd.out_pred = 1'b1;
                    if (sts.upd) begin
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_SWEEP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RDW: begin
                if (sts.out_free) begin
                    cmd.out_read = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (!sts.sweep_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_sweep_only_after_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_start |-> (state_reg == ST_DEC) && sts.upd)
        else $error("sweep started without an update decision");
    a_sweep_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.sweep_start) |-> !s_tready)
        else $error("request taken while weights are being updated");
    a_result_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_pred || cmd.out_read) |-> sts.out_free)
        else $error("result loaded into a full output register");
`endif

endmodule
`default_nettype wire

>>> sv/smm_dp.sv
`default_nettype none
module smm_dp #(
    parameter int SEQ_LEN     = 9,
    parameter int ALPHABET    = 20,
    parameter int WEIGHT_BITS = 24
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire smm_pkg::cmd_t                        cmd,
    output smm_pkg::sts_t                             sts,
    input  wire logic        [smm_pkg::RES_W-1:0]     in_residue,
    input  wire logic signed [smm_pkg::VAL_W-1:0]     in_target,
    input  wire logic        [smm_pkg::ADDR_W-1:0]    in_addr,
    input  wire logic signed [smm_pkg::VAL_W-1:0]     in_wval,
    input  wire logic                                 cfg_valid,
    input  wire logic        [smm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [smm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                                 m_tready,
    output logic                                      m_tvalid,
    output logic                                      m_kind,
    output logic signed [smm_pkg::VAL_W-1:0]          m_pred,
    output logic                                      m_upd,
    output logic                                      m_lerr,
    output logic signed [smm_pkg::VAL_W-1:0]          m_rval
);
    import smm_pkg::*;

    localparam int DEPTH = SEQ_LEN * ALPHABET;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SEQ_LEN + 2);
    localparam int BW    = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
    localparam int RW    = $clog2(ALPHABET);
    localparam int WB    = WEIGHT_BITS;
    localparam int PW    = 32 + WB;
    localparam int NW    = WB + 28;
    localparam logic signed [NW-1:0] W_MAX = NW'((64'sd1 <<< (WB - 1)) - 64'sd1);
    localparam logic signed [NW-1:0] W_MIN = -W_MAX - NW'(1);
    localparam logic signed [NW-1:0] V_MAX = NW'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
    localparam logic signed [NW-1:0] V_MIN = -V_MAX - NW'(1);
    localparam logic signed [NW-1:0] S_MAX = NW'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
    localparam logic signed [NW-1:0] S_MIN = -S_MAX - NW'(1);

    // configuration
    logic [ETA_W-1:0]   eta_reg, lambda_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               train_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_reg    <= ETA_W'(655);
            lambda_reg <= '0;
            limit_reg  <= LIMIT_W'(42950);
            train_reg  <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ETA:    eta_reg    <= cfg_data[ETA_W-1:0];
                CFG_LAMBDA: lambda_reg <= cfg_data[ETA_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_TRAIN:  train_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // weight memory
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic signed [WB-1:0] ram_wdata, ram_rdata;

    smm_ram #(.WIDTH(WB), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequence state
    logic [CW-1:0]          pos_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [RES_W-1:0]       buf_reg [SEQ_LEN];
    logic signed [VAL_W-1:0] target_reg;
    logic                   res_sel_reg;
    logic                   rd_ok_reg;
    logic                   sel_now, ld_ok, addr_ok;
    logic [AW-1:0]          res_addr, ext_addr;
    logic signed [NW-1:0]   rd_ext, sum_wide, ld_wide;
    logic signed [WB-1:0]   ld_sat;
    logic signed [VAL_W-1:0] rd_sat;

    assign sel_now  = (pos_reg < CW'(SEQ_LEN)) && (32'(in_residue) < 32'(ALPHABET));
    assign res_addr = AW'(32'(pos_reg) * 32'(ALPHABET) + 32'(in_residue));
    assign addr_ok  = 32'(in_addr) < 32'(DEPTH);
    assign ext_addr = AW'(32'(in_addr));
    assign ld_ok    = addr_ok;
    assign rd_ext   = NW'(ram_rdata);
    assign sum_wide = NW'(sum_reg) + rd_ext;
    assign ld_wide  = NW'(in_wval);

    always_comb begin
        if (ld_wide > W_MAX)      ld_sat = WB'(W_MAX);
        else if (ld_wide < W_MIN) ld_sat = WB'(W_MIN);
        else                      ld_sat = WB'(ld_wide);
        if (rd_ext > V_MAX)      rd_sat = VAL_W'(V_MAX);
        else if (rd_ext < V_MIN) rd_sat = VAL_W'(V_MIN);
        else                     rd_sat = VAL_W'(rd_ext);
    end

    // error and step
    logic signed [VAL_W-1:0]  p_reg;
    logic                     lerr_reg, dneg_reg;
    logic [DMAG_W-1:0]        dm_reg;
    logic [2*DMAG_W-1:0]      sq_reg;
    logic [DMAG_W-1:0]        step_reg;
    logic [2*ETA_W-1:0]       el_reg;
    logic signed [VAL_W-1:0]  p_now;
    logic signed [VAL_W+1:0]  d_now;
    logic [ETA_W+DMAG_W-1:0]  step_prod;

    always_comb begin
        if (NW'(sum_reg) > V_MAX)      p_now = VAL_W'(V_MAX);
        else if (NW'(sum_reg) < V_MIN) p_now = VAL_W'(V_MIN);
        else                           p_now = VAL_W'(sum_reg);
    end
    assign d_now     = (VAL_W+2)'(p_now) - (VAL_W+2)'(target_reg);
    assign step_prod = (ETA_W+DMAG_W)'(eta_reg) * (ETA_W+DMAG_W)'(dm_reg);
    assign sts.upd   = !lerr_reg && train_reg && (sq_reg > (2*DMAG_W)'(limit_reg));

    // update sweep
    logic                 sw_run_reg;
    logic [AW-1:0]        sw_cnt_reg;
    logic [BW-1:0]        sw_pos_reg;
    logic [RW-1:0]        sw_r_reg;
    logic                 s1_v_reg, s1_sel_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic                 s2_v_reg, s2_sel_reg, s2_neg_reg;
    logic [AW-1:0]        s2_addr_reg;
    logic signed [WB-1:0] s2_w_reg;
    logic [PW-1:0]        s2_prod_reg;
    logic                 sw_sel;
    logic [WB-1:0]        wmag;
    logic [PW-1:0]        prod_rnd;
    logic signed [NW-1:0] decay_s, step_s, nw_wide;
    logic signed [WB-1:0] nw_sat;

    assign sw_sel   = 32'(buf_reg[sw_pos_reg]) == 32'(sw_r_reg);
    assign wmag     = ram_rdata[WB-1] ? WB'(-ram_rdata) : WB'(ram_rdata);
    assign prod_rnd = s2_prod_reg + PW'(64'd1 << 30);
    assign decay_s  = s2_neg_reg ? -NW'(prod_rnd >> 31) : NW'(prod_rnd >> 31);
    assign step_s   = dneg_reg ? -NW'(step_reg) : NW'(step_reg);
    assign nw_wide  = NW'(s2_w_reg) - decay_s - (s2_sel_reg ? step_s : NW'(0));

    always_comb begin
        if (nw_wide > W_MAX)      nw_sat = WB'(W_MAX);
        else if (nw_wide < W_MIN) nw_sat = WB'(W_MIN);
        else                      nw_sat = WB'(nw_wide);
    end

    assign sts.sweep_busy = sw_run_reg | s1_v_reg | s2_v_reg;

    // memory port steering
    always_comb begin
        ram_re = sw_run_reg | cmd.rd_issue | (cmd.res_in & sel_now);
        priority if (sw_run_reg) ram_raddr = sw_cnt_reg;
        else if (cmd.rd_issue)   ram_raddr = ext_addr;
        else                     ram_raddr = res_addr;
        ram_we    = s2_v_reg | (cmd.load & ld_ok);
        ram_waddr = s2_v_reg ? s2_addr_reg : ext_addr;
        ram_wdata = s2_v_reg ? nw_sat : ld_sat;
    end

    // output register
    logic                    out_v_reg;
    logic                    kind_reg, upd_reg, olerr_reg;
    logic signed [VAL_W-1:0] pred_reg, rval_reg;

    assign sts.out_free = !out_v_reg || m_tready;
    assign m_tvalid = out_v_reg;
    assign m_kind   = kind_reg;
    assign m_pred   = pred_reg;
    assign m_upd    = upd_reg;
    assign m_lerr   = olerr_reg;
    assign m_rval   = rval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            out_v_reg  <= 1'b0;
            sw_run_reg <= 1'b0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
        end else begin
            if (cmd.res_in) begin
                pos_reg <= sel_now || (pos_reg < CW'(SEQ_LEN)) ? pos_reg + CW'(1)
                                                               : CW'(SEQ_LEN + 1);
            end else if (cmd.out_pred) begin
                pos_reg <= '0;
            end
            if (cmd.add && res_sel_reg) begin
                if (sum_wide > S_MAX)      sum_reg <= SUM_W'(S_MAX);
                else if (sum_wide < S_MIN) sum_reg <= SUM_W'(S_MIN);
                else                       sum_reg <= SUM_W'(sum_wide);
            end else if (cmd.out_pred) begin
                sum_reg <= '0;
            end
            if (cmd.out_pred || cmd.out_read) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
            if (cmd.sweep_start) begin
                sw_run_reg <= 1'b1;
            end else if (sw_run_reg && sw_cnt_reg == AW'(DEPTH - 1)) begin
                sw_run_reg <= 1'b0;
            end
            s1_v_reg <= sw_run_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_in) begin
            if (pos_reg < CW'(SEQ_LEN)) begin
                buf_reg[pos_reg[BW-1:0]] <= in_residue;
            end
            res_sel_reg <= sel_now;
            target_reg  <= in_target;
        end
        if (cmd.rd_issue) begin
            rd_ok_reg <= addr_ok;
        end
        if (cmd.fin) begin
            p_reg    <= p_now;
            lerr_reg <= pos_reg != CW'(SEQ_LEN);
            dneg_reg <= d_now < 0;
            dm_reg   <= d_now < 0 ? DMAG_W'(-d_now) : DMAG_W'(d_now);
        end
        if (cmd.sq) begin
            sq_reg   <= (2*DMAG_W)'(dm_reg) * (2*DMAG_W)'(dm_reg);
            step_reg <= DMAG_W'((step_prod + (ETA_W+DMAG_W)'(32768)) >> 16);
            el_reg   <= (2*ETA_W)'(eta_reg) * (2*ETA_W)'(lambda_reg);
        end
        if (cmd.out_pred) begin
            kind_reg  <= KIND_PRED;
            pred_reg  <= p_reg;
            upd_reg   <= sts.upd;
            olerr_reg <= lerr_reg;
            rval_reg  <= '0;
        end else if (cmd.out_read) begin
            kind_reg  <= KIND_READ;
            pred_reg  <= '0;
            upd_reg   <= 1'b0;
            olerr_reg <= 1'b0;
            rval_reg  <= rd_ok_reg ? rd_sat : '0;
        end
        // advance the sweep address, walking position and residue alongside
        if (cmd.sweep_start) begin
            sw_cnt_reg <= '0;
            sw_pos_reg <= '0;
            sw_r_reg   <= '0;
        end else if (sw_run_reg) begin
            sw_cnt_reg <= sw_cnt_reg + AW'(1);
            if (sw_r_reg == RW'(ALPHABET - 1)) begin
                sw_r_reg   <= '0;
                sw_pos_reg <= sw_pos_reg + BW'(1);
            end else begin
                sw_r_reg <= sw_r_reg + RW'(1);
            end
        end
        s1_addr_reg <= sw_cnt_reg;
        s1_sel_reg  <= sw_sel;
        s2_addr_reg <= s1_addr_reg;
        s2_sel_reg  <= s1_sel_reg;
        s2_neg_reg  <= ram_rdata[WB-1];
        s2_w_reg    <= ram_rdata;
        s2_prod_reg <= PW'(el_reg) * PW'(wmag);
    end

`ifndef NO_ASSERTIONS
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.out_pred && cmd.out_read))
        else $error("two results in one cycle");
    a_sweep_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_start |=> sts.sweep_busy)
        else $error("sweep did not start");
    a_no_load_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.sweep_busy |-> !cmd.load && !cmd.res_in && !cmd.rd_issue)
        else $error("request handled during weight update");
    a_sweep_pipe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_v_reg |-> $past(s1_v_reg))
        else $error("sweep pipeline out of step");
`endif

endmodule
`default_nettype wire
